// ===== rtl/c8x_pkg.sv =====
`default_nettype none
package c8x_pkg;

	// command codes
	localparam logic [1:0] CMD_EXEC  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_ROW   = 2'd3;

	// configuration register indexes
	localparam logic REG_VWRAP = 1'b0;
	localparam logic REG_FONT  = 1'b1;

	localparam int CFG_W = 12;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] opcode;
		logic [15:0] key_mask;
		logic [7:0]  random_byte;
		logic [11:0] mem_addr;
		logic [7:0]  write_byte;
	} c8x_in_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] index_value;
		logic [7:0]  flag_value;
		logic [63:0] read_value;
		logic [7:0]  delay_value;
		logic [7:0]  sound_value;
	} c8x_out_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       latch;     // capture input item
		logic       exec;      // single-cycle register op
		logic       clr_row;   // clear screen row at step counter
		logic       mem_rd;    // issue memory read at computed address
		logic       mem_wr;    // write memory at computed address
		logic       load_reg;  // FX65: reg[step] <= mem data
		logic       row_rd;    // read screen row (sprite line or row read)
		logic       row_wr;    // write back xored row
		logic       step_clr;
		logic       step_inc;
		logic       done;      // drive result
	} c8x_ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] op_hi;
		logic [7:0] nn;
		logic [3:0] x;
		logic [3:0] n;
		logic [6:0] step;
	} c8x_sts_t;

endpackage
`default_nettype wire

// ===== rtl/c8x_ctrl.sv =====
`default_nettype none
module c8x_ctrl
	import c8x_pkg::*;
#(
	parameter int SCREEN_H = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire c8x_sts_t sts,
	output c8x_ctl_t      ctl
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_CLS   = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;   // memory read data registered
	localparam logic [3:0] S_RDW   = 4'd4;   // memory data valid
	localparam logic [3:0] S_BCD   = 4'd5;
	localparam logic [3:0] S_ST    = 4'd6;
	localparam logic [3:0] S_LD    = 4'd7;
	localparam logic [3:0] S_LDW   = 4'd8;
	localparam logic [3:0] S_SPR   = 4'd9;
	localparam logic [3:0] S_SPRW  = 4'd10;
	localparam logic [3:0] S_SPRX  = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				ctl.step_clr = 1'b1;
				state_d = S_DONE;
				if (sts.cmd == CMD_EXEC) begin
					ctl.exec = 1'b1;
					if (sts.op_hi == 4'h0 && sts.nn == 8'hE0 && sts.x == 4'h0) begin
						state_d = S_CLS;
					end else if (sts.op_hi == 4'hD) begin
						state_d = (sts.n == 4'h0) ? S_DONE : S_SPR;
					end else if (sts.op_hi == 4'hF && sts.nn == 8'h33) begin
						state_d = S_BCD;
					end else if (sts.op_hi == 4'hF && sts.nn == 8'h55) begin
						state_d = S_ST;
					end else if (sts.op_hi == 4'hF && sts.nn == 8'h65) begin
						state_d = S_LD;
					end
				end else if (sts.cmd == CMD_WRITE) begin
					ctl.mem_wr = 1'b1;
				end else if (sts.cmd == CMD_READ) begin
					ctl.mem_rd = 1'b1;
					state_d = S_RD;
				end else begin
					ctl.row_rd = 1'b1;
					state_d = S_RD;
				end
			end
			S_CLS: begin
				ctl.clr_row = 1'b1;
				ctl.step_inc = 1'b1;
				if (sts.step == 7'(SCREEN_H - 1)) begin
					state_d = S_DONE;
				end
			end
			S_RD: state_d = S_RDW;
			S_RDW: begin
				ctl.done = 1'b1;
				state_d = S_IDLE;
			end
			S_BCD: begin
				ctl.mem_wr = 1'b1;
				ctl.step_inc = 1'b1;
				if (sts.step == 7'd2) begin
					state_d = S_DONE;
				end
			end
			S_ST: begin
				ctl.mem_wr = 1'b1;
				ctl.step_inc = 1'b1;
				if (sts.step[3:0] == sts.x) begin
					state_d = S_DONE;
				end
			end
			S_LD: begin
				ctl.mem_rd = 1'b1;
				state_d = S_LDW;
			end
			S_LDW: begin
				ctl.load_reg = 1'b1;
				ctl.step_inc = 1'b1;
				state_d = (sts.step[3:0] == sts.x) ? S_DONE : S_LD;
			end
			S_SPR: begin
				ctl.mem_rd = 1'b1;
				ctl.row_rd = 1'b1;
				state_d = S_SPRW;
			end
			S_SPRW: state_d = S_SPRX;
			S_SPRX: begin
				ctl.row_wr = 1'b1;
				ctl.step_inc = 1'b1;
				state_d = (sts.step[3:0] == sts.n - 4'd1) ? S_DONE : S_SPR;
			end
			S_DONE: begin
				ctl.done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// a result is only given while working
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |-> busy) else $error("result outside of an item");
	// accept leads to decode
	a_latch: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.latch |=> state_q == S_DEC) else $error("missed decode");
	// done returns to idle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> !busy) else $error("not idle after result");

endmodule
`default_nettype wire

// ===== rtl/c8x_dpath.sv =====
`default_nettype none
module c8x_dpath
	import c8x_pkg::*;
#(
	parameter int MEM_BYTES   = 4096,
	parameter int SCREEN_W    = 64,
	parameter int SCREEN_H    = 32,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire c8x_in_t  din,
	input  wire logic     vwrap,
	input  wire logic [11:0] font_base,
	input  wire c8x_ctl_t ctl,
	output c8x_sts_t      sts,
	output logic          done,
	output c8x_out_t      dout
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int HW = $clog2(SCREEN_H);
	localparam int XW = $clog2(SCREEN_W);
	localparam int SW = $clog2(STACK_DEPTH);

	c8x_in_t item_q;
	logic [7:0]  v_q [16];
	logic [15:0] i_q, pc_q;
	logic [SW-1:0] sp_q;
	logic [15:0] stk_q [STACK_DEPTH];
	logic [7:0]  mem_q [MEM_BYTES];
	logic [7:0]  mrd_q;
	logic [SCREEN_W-1:0] scr_q [SCREEN_H];
	logic [SCREEN_W-1:0] row_q;
	logic [7:0]  dly_q, snd_q;
	logic [6:0]  step_q;
	logic [63:0] rd_q;
	logic        hit_q;

	// decode fields
	logic [3:0]  x, y, n;
	logic [7:0]  nn, vx, vy;
	logic [11:0] nnn;
	assign x   = item_q.opcode[11:8];
	assign y   = item_q.opcode[7:4];
	assign n   = item_q.opcode[3:0];
	assign nn  = item_q.opcode[7:0];
	assign nnn = item_q.opcode[11:0];
	assign vx  = v_q[x];
	assign vy  = v_q[y];

	assign sts.cmd   = item_q.cmd;
	assign sts.op_hi = item_q.opcode[15:12];
	assign sts.nn    = nn;
	assign sts.x     = x;
	assign sts.n     = n;
	assign sts.step  = step_q;

	// BCD digits of VX
	logic [7:0] hund, tens, ones, rem1;
	always_comb begin
		hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
		rem1 = vx - 8'(hund * 8'd100);
		tens = 8'((16'(rem1) * 16'd205) >> 11);
		ones = rem1 - 8'(tens * 8'd10);
	end

	// memory address and write data
	logic [AW-1:0] maddr;
	logic [7:0]    mwdata;
	always_comb begin
		if (item_q.cmd != CMD_EXEC) begin
			maddr = AW'(item_q.mem_addr);
		end else begin
			maddr = AW'(i_q + 16'(step_q));
		end
		case (step_q[1:0])
			2'd0: mwdata = hund;
			2'd1: mwdata = tens;
			default: mwdata = ones;
		endcase
		if (item_q.cmd == CMD_WRITE) begin
			mwdata = item_q.write_byte;
		end else if (nn == 8'h55) begin
			mwdata = v_q[step_q[3:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem_q[maddr] <= mwdata;
		end
		if (ctl.mem_rd) begin
			mrd_q <= mem_q[maddr];
		end
	end

	// sprite row target
	logic [7:0]    ty8;
	logic [HW-1:0] ty;
	logic          ty_ok;
	always_comb begin
		ty8   = vy + 8'(step_q);
		ty    = HW'(ty8);
		ty_ok = vwrap || (ty8 < 8'(SCREEN_H));
	end

	logic [HW-1:0] rsel;
	assign rsel = (item_q.cmd == CMD_ROW) ? HW'(item_q.mem_addr) : ty;

	// sprite mask: 8 bits placed at column VX, wrapping
	logic [SCREEN_W-1:0] smask;
	always_comb begin
		smask = '0;
		for (int c = 0; c < 8; c++) begin
			if (mrd_q[7-c]) begin
				smask[SCREEN_W-1-int'(XW'(vx + 8'(c)))] = 1'b1;
			end
		end
	end

	// screen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < SCREEN_H; r++) scr_q[r] <= '0;
		end else begin
			if (ctl.clr_row) begin
				scr_q[HW'(step_q)] <= '0;
			end
			if (ctl.row_wr && ty_ok) begin
				scr_q[ty] <= row_q ^ smask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.row_rd) begin
			row_q <= scr_q[rsel];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && item_q.opcode[15:12] == 4'h2) begin
			stk_q[sp_q] <= pc_q;
		end
	end

	// item capture and step counter
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctl.step_clr) begin
			step_q <= '0;
		end else if (ctl.step_inc) begin
			step_q <= step_q + 7'd1;
		end
	end

	// architectural registers
	logic [8:0]  add9;
	logic [16:0] isum;
	logic [15:0] pc2, pc4;
	logic [3:0]  hikey;
	logic        anykey, keyb;
	assign pc2 = pc_q + 16'd2;
	assign pc4 = pc_q + 16'd4;
	assign add9 = 9'(vx) + 9'(vy);
	assign isum = 17'(i_q) + 17'(vx);
	assign keyb = item_q.key_mask[vx[3:0]];
	always_comb begin
		hikey = '0;
		anykey = |item_q.key_mask;
		for (int k = 0; k < 16; k++) begin
			if (item_q.key_mask[k]) hikey = 4'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 16; r++) v_q[r] <= '0;
			i_q   <= '0;
			pc_q  <= 16'h0200;
			sp_q  <= '0;
			dly_q <= '0;
			snd_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.exec) begin
				pc_q <= pc2;
				hit_q <= 1'b0;
				case (item_q.opcode[15:12])
					4'h0: begin
						if (item_q.opcode == 16'h00EE) begin
							sp_q <= sp_q - SW'(1);
							pc_q <= stk_q[sp_q - SW'(1)] + 16'd2;
						end
					end
					4'h1: pc_q <= 16'(nnn);
					4'h2: begin
						sp_q <= sp_q + SW'(1);
						pc_q <= 16'(nnn);
					end
					4'h3: if (vx == nn) pc_q <= pc4;
					4'h4: if (vx != nn) pc_q <= pc4;
					4'h5: if (vx == vy) pc_q <= pc4;
					4'h6: v_q[x] <= nn;
					4'h7: v_q[x] <= vx + nn;
					4'h8: begin
						case (n)
							4'h0: v_q[x] <= vy;
							4'h1: v_q[x] <= vx | vy;
							4'h2: v_q[x] <= vx & vy;
							4'h3: v_q[x] <= vx ^ vy;
							4'h4: begin
								v_q[x] <= add9[7:0];
								v_q[15] <= {7'd0, add9[8]};
							end
							4'h5: begin
								v_q[x] <= vx - vy;
								v_q[15] <= {7'd0, vx >= vy};
							end
							4'h6: begin
								v_q[x] <= vx >> 1;
								v_q[15] <= {7'd0, vx[0]};
							end
							4'h7: begin
								v_q[x] <= vy - vx;
								v_q[15] <= {7'd0, vy >= vx};
							end
							4'hE: begin
								v_q[x] <= {vx[6:0], 1'b0};
								v_q[15] <= {7'd0, vx[7]};
							end
							default: ;
						endcase
					end
					4'h9: if (vx != vy) pc_q <= pc4;
					4'hA: i_q <= 16'(nnn);
					4'hB: pc_q <= 16'(nnn) + 16'(v_q[0]);
					4'hC: v_q[x] <= item_q.random_byte & nn;
					4'hE: begin
						if (nn == 8'h9E && keyb) pc_q <= pc4;
						if (nn == 8'hA1 && !keyb) pc_q <= pc4;
					end
					4'hF: begin
						case (nn)
							8'h07: v_q[x] <= dly_q;
							8'h0A: if (anykey) v_q[x] <= 8'(hikey);
							8'h15: dly_q <= vx;
							8'h18: snd_q <= vx;
							8'h1E: begin
								i_q <= isum[15:0];
								v_q[15] <= {7'd0, isum > 17'h00FFF};
							end
							8'h29: i_q <= 16'(font_base) + 16'(vx[3:0]) * 16'd5;
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			if (ctl.load_reg) begin
				v_q[step_q[3:0]] <= mrd_q;
			end
			if (ctl.row_wr && ty_ok && ((row_q & smask) != '0)) begin
				hit_q <= 1'b1;
			end
			if (ctl.step_clr && item_q.opcode[15:12] == 4'hD &&
					item_q.cmd == CMD_EXEC) begin
				hit_q <= 1'b0;
			end
			if (ctl.done && item_q.cmd == CMD_EXEC && item_q.opcode[15:12] == 4'hD) begin
				v_q[15] <= {7'd0, hit_q ||
					(ctl.row_wr && ty_ok && ((row_q & smask) != '0))};
			end
		end
	end

	// read value
	always_comb begin
		rd_q = '0;
		if (item_q.cmd == CMD_READ) begin
			rd_q = {56'd0, mrd_q};
		end else if (item_q.cmd == CMD_ROW &&
				item_q.mem_addr < 12'(SCREEN_H)) begin
			rd_q = row_q[SCREEN_W-1 -: 64];
		end
	end

	// result register
	logic draw_end;
	assign draw_end = ctl.done && item_q.cmd == CMD_EXEC && item_q.opcode[15:12] == 4'hD;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.done;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.done) begin
			dout.read_value <= rd_q;
		end
	end
	assign dout.next_pc     = pc_q;
	assign dout.index_value = i_q;
	assign dout.flag_value  = v_q[15];
	assign dout.delay_value = dly_q;
	assign dout.sound_value = snd_q;

	// flag after a draw is only 0 or 1
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(draw_end) |-> v_q[15][7:1] == 7'd0) else $error("bad collision flag");
	// a result strobe lasts one cycle
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	// step counter bound during a draw
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.row_wr |-> step_q < 7'd16) else $error("sprite step overrun");

endmodule
`default_nettype wire

// ===== rtl/chip8_instruction_execute.sv =====
// Channel  | Signals                         | Transfer
// input    | start, busy, in_item            | start && !busy
// result   | result_valid, result            | result_valid (one cycle)
// config   | cfg_we, cfg_index, cfg_data     | cfg_we
//
// Reads wait for memory data; 00E0 clears the screen row by row, FX33 writes
// three BCD digits, FX55 / FX65 store / load V0..VX in turn and DXYN does a
// read-modify-write per sprite row on the single-port memory and screen.
// arst_n clears registers, pc to 0x200, the screen and the timers.
// The result cannot be stalled; start is ignored while busy.
`default_nettype none
module chip8_instruction_execute
	import c8x_pkg::*;
#(
	parameter int MEM_BYTES   = 4096,
	parameter int SCREEN_W    = 64,
	parameter int SCREEN_H    = 32,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire c8x_in_t          in_item,
	output logic                  result_valid,
	output c8x_out_t              result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic        vwrap_q;
	logic [11:0] font_q;
	c8x_ctl_t    ctl;
	c8x_sts_t    sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vwrap_q <= 1'b1;
			font_q  <= 12'd80;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VWRAP: vwrap_q <= cfg_data[0];
				REG_FONT:  font_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	c8x_ctrl #(.SCREEN_H(SCREEN_H)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .ctl(ctl)
	);

	c8x_dpath #(
		.MEM_BYTES(MEM_BYTES), .SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H), .STACK_DEPTH(STACK_DEPTH)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .din(in_item), .vwrap(vwrap_q),
		.font_base(font_q), .ctl(ctl), .sts(sts),
		.done(result_valid), .dout(result)
	);

endmodule
`default_nettype wire
